/* sv/tbp_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants and types of the token bucket policer.
package tbp_pkg;

    localparam int TIME_BITS  = 48;
    localparam int TOKEN_BITS = 24;
    localparam int LEN_BITS   = 16;
    localparam int RATE_BITS  = 16;
    localparam int WAIT_BITS  = 16;

    // quotient width of the wait division: the deficit needs TOKEN_BITS + 1 bits
    localparam int DIV_BITS   = TOKEN_BITS + 1;
    localparam int CNT_BITS   = $clog2(DIV_BITS);

    // elapsed ticks that matter for the refill product: up to 2^(TOKEN_BITS+1)
    localparam int DIFFM_BITS = TOKEN_BITS + 2;
    localparam int PROD_BITS  = DIFFM_BITS + RATE_BITS;

    localparam int ALU_BITS   = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 2;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = (TOKEN_BITS > RATE_BITS) ? TOKEN_BITS : RATE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_CAPACITY = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFILL_RATE     = CFG_INDEX_BITS'(1);

    localparam logic [TOKEN_BITS-1:0] CAPACITY_RESET = TOKEN_BITS'(65535);
    localparam logic [RATE_BITS-1:0]  RATE_RESET     = RATE_BITS'(1);

    localparam logic [WAIT_BITS-1:0] WAIT_MAX = {WAIT_BITS{1'b1}};

    typedef struct packed {
        logic sub;
    } alu_ctrl_t;

    typedef struct packed {
        logic [ALU_BITS-1:0] sum;
        logic                neg;
        logic                zero;
    } alu_res_t;

endpackage

/* sv/tbp_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the policer: packet items, result items, register writes.
interface tbp_pkt_if;
    import tbp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] arrival_time;
    logic [LEN_BITS-1:0]  packet_length;
    logic                 is_retry;

    modport source (output valid, arrival_time, packet_length, is_retry, input ready);
    modport sink   (input valid, arrival_time, packet_length, is_retry, output ready);
endinterface

interface tbp_res_if;
    import tbp_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         conforms;
    logic [WAIT_BITS-1:0]         wait_ticks;
    logic signed [TOKEN_BITS:0]   tokens_left;

    modport source (output valid, conforms, wait_ticks, tokens_left, input ready);
    modport sink   (input valid, conforms, wait_ticks, tokens_left, output ready);
endinterface

interface tbp_cfg_if;
    import tbp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tbp_alu.sv */
`timescale 1ns / 1ps
// Shared add/subtract unit with sign and zero flags, used by the arithmetic steps of the sequencer.
module tbp_alu (
    input  logic [tbp_pkg::ALU_BITS-1:0] a,
    input  logic [tbp_pkg::ALU_BITS-1:0] b,
    input  tbp_pkg::alu_ctrl_t           ctrl,
    output tbp_pkg::alu_res_t            res
);
    import tbp_pkg::*;

    logic [ALU_BITS-1:0] b_op;
    logic [ALU_BITS-1:0] sum;

    always_comb
    begin
        b_op = ctrl.sub ? ~b : b;
        sum  = a + b_op + ALU_BITS'(ctrl.sub);
    end

    assign res.sum  = sum;
    assign res.neg  = sum[ALU_BITS-1];
    assign res.zero = (sum == '0);

endmodule

/* sv/tbp_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration registers: bucket capacity and refill rate.
module tbp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    tbp_cfg_if.sink                       cfg,
    input  logic                          enable,
    output logic [tbp_pkg::TOKEN_BITS-1:0] capacity,
    output logic [tbp_pkg::RATE_BITS-1:0]  rate
);
    import tbp_pkg::*;

    logic [TOKEN_BITS-1:0] cap_reg;
    logic [TOKEN_BITS-1:0] cap_next;
    logic [RATE_BITS-1:0]  rate_reg;
    logic [RATE_BITS-1:0]  rate_next;

    assign cfg.ready = enable;

    always_comb
    begin
        cap_next  = cap_reg;
        rate_next = rate_reg;
        if (cfg.valid && enable)
        begin
            case (cfg.index)
                REG_BUCKET_CAPACITY: cap_next  = cfg.data[TOKEN_BITS-1:0];
                REG_REFILL_RATE:     rate_next = cfg.data[RATE_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAPACITY_RESET;
            rate_reg <= RATE_RESET;
        end
        else
        begin
            cap_reg  <= cap_next;
            rate_reg <= rate_next;
        end
    end

    assign capacity = cap_reg;
    assign rate     = rate_reg;

endmodule

/* sv/token_bucket_policer.sv */
`timescale 1ns / 1ps
// Token bucket policer: one packet item in, one verdict item out, one item in work at a time.
//
// The policer takes one packet item at a time. A small sequencer drives a single shared
// add/subtract unit through the refill (elapsed ticks, multiply by the rate, add, clamp to
// capacity), the length check and the deduction. A packet that conforms, or a retry of the
// delayed packet, has its result registered without a division; a delayed packet with a
// nonzero rate also runs a restoring division of the deficit by the rate on the same unit,
// one quotient bit per cycle for TOKEN_BITS + 1 quotient bits. The next packet is taken in
// the cycle after the result is registered, while that result may still wait in the output
// register. Register writes are taken only while no packet is in work.
module token_bucket_policer (
    input  logic      clk,
    input  logic      rst_n,
    tbp_pkt_if.sink   pkt,
    tbp_res_if.source res,
    tbp_cfg_if.sink   cfg
);
    import tbp_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DIFF  = 11'b000_0000_0010,
        S_BIG   = 11'b000_0000_0100,
        S_ADD   = 11'b000_0000_1000,
        S_CLAMP = 11'b000_0001_0000,
        S_LEN   = 11'b000_0010_0000,
        S_SUB   = 11'b000_0100_0000,
        S_NUM   = 11'b000_1000_0000,
        S_DIV   = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    localparam logic [ALU_BITS-1:0] BIG_LIMIT = ALU_BITS'(1) << (TOKEN_BITS + 1);
    localparam logic [ALU_BITS-1:0] ALU_ONE   = ALU_BITS'(1);
    localparam logic signed [TOKEN_BITS:0] TOK_MIN = {1'b1, {TOKEN_BITS{1'b0}}};

    function automatic logic [ALU_BITS-1:0] sext_tok(input logic [TOKEN_BITS:0] v);
        sext_tok = {{(ALU_BITS - TOKEN_BITS - 1){v[TOKEN_BITS]}}, v};
    endfunction

    logic [TOKEN_BITS-1:0] capacity;
    logic [RATE_BITS-1:0]  rate;
    logic                  idle;

    alu_ctrl_t           alu_ctrl;
    logic [ALU_BITS-1:0] alu_a;
    logic [ALU_BITS-1:0] alu_b;
    alu_res_t            alu_res;

    state_t                      state_reg, state_next;
    logic signed [TOKEN_BITS:0]  tok_reg, tok_next;
    logic [TIME_BITS-1:0]        last_reg, last_next;
    logic                        pend_reg, pend_next;
    logic                        ovalid_reg, ovalid_next;

    logic [TIME_BITS-1:0]        now_reg, now_next;
    logic [LEN_BITS-1:0]         len_reg, len_next;
    logic                        retry_reg, retry_next;
    logic [ALU_BITS-1:0]         acc_reg, acc_next;
    logic [PROD_BITS-1:0]        prod_reg, prod_next;
    logic                        big_reg, big_next;
    logic [DIV_BITS-1:0]         num_reg, num_next;
    logic [RATE_BITS-1:0]        rem_reg, rem_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        ok_reg, ok_next;
    logic [WAIT_BITS-1:0]        wait_reg, wait_next;
    logic                        oconf_reg, oconf_next;
    logic [WAIT_BITS-1:0]        owait_reg, owait_next;
    logic signed [TOKEN_BITS:0]  otok_reg, otok_next;

    assign idle = (state_reg == S_IDLE);

    tbp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .enable   (idle),
        .capacity (capacity),
        .rate     (rate)
    );

    tbp_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .ctrl (alu_ctrl),
        .res  (alu_res)
    );

    assign pkt.ready = idle;

    always_comb
    begin
        state_next  = state_reg;
        tok_next    = tok_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg && !res.ready;
        now_next    = now_reg;
        len_next    = len_reg;
        retry_next  = retry_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        big_next    = big_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        ok_next     = ok_reg;
        wait_next   = wait_reg;
        oconf_next  = oconf_reg;
        owait_next  = owait_reg;
        otok_next   = otok_reg;
        alu_a       = '0;
        alu_b       = '0;
        alu_ctrl    = '{sub: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (pkt.valid)
                begin
                    now_next   = pkt.arrival_time;
                    len_next   = pkt.packet_length;
                    retry_next = pkt.is_retry;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                alu_a     = ALU_BITS'(now_reg);
                alu_b     = ALU_BITS'(last_reg);
                alu_ctrl  = '{sub: 1'b1};
                acc_next  = alu_res.sum;
                last_next = now_reg;
                // no elapsed time: skip refill and clamp
                state_next = (alu_res.neg || alu_res.zero) ? S_LEN : S_BIG;
            end
            S_BIG:
            begin
                alu_a      = BIG_LIMIT;
                alu_b      = acc_reg;
                alu_ctrl   = '{sub: 1'b1};
                big_next   = alu_res.neg && (rate != '0);
                prod_next  = PROD_BITS'(acc_reg[DIFFM_BITS-1:0]) * PROD_BITS'(rate);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // saturated refill fills to capacity
                alu_a      = big_reg ? ALU_BITS'(capacity) : sext_tok(tok_reg);
                alu_b      = big_reg ? '0 : ALU_BITS'(prod_reg);
                acc_next   = alu_res.sum;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                alu_a      = acc_reg;
                alu_b      = ALU_BITS'(capacity);
                alu_ctrl   = '{sub: 1'b1};
                tok_next   = alu_res.neg ? acc_reg[TOKEN_BITS:0] : {1'b0, capacity};
                state_next = S_LEN;
            end
            S_LEN:
            begin
                if (retry_reg && pend_reg)
                begin
                    pend_next  = 1'b0;
                    ok_next    = 1'b1;
                    wait_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    alu_a      = ALU_BITS'(len_reg);
                    alu_b      = sext_tok(tok_reg);
                    alu_ctrl   = '{sub: 1'b1};
                    acc_next   = alu_res.sum;
                    ok_next    = alu_res.neg || alu_res.zero;
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                alu_a    = sext_tok(tok_reg);
                alu_b    = ALU_BITS'(len_reg);
                alu_ctrl = '{sub: 1'b1};
                // below the floor: negative with the floor bit clear
                if (alu_res.neg && !alu_res.sum[TOKEN_BITS])
                    tok_next = TOK_MIN;
                else
                    tok_next = alu_res.sum[TOKEN_BITS:0];
                if (ok_reg)
                begin
                    wait_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    pend_next = 1'b1;
                    if (rate == '0)
                    begin
                        wait_next  = WAIT_MAX;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                // ceil(d / r) = floor((d - 1) / r) + 1 for d > 0
                alu_a      = acc_reg;
                alu_b      = ALU_ONE;
                alu_ctrl   = '{sub: 1'b1};
                num_next   = alu_res.sum[DIV_BITS-1:0];
                rem_next   = '0;
                cnt_next   = CNT_BITS'(DIV_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                alu_a    = ALU_BITS'({rem_reg, num_reg[DIV_BITS-1]});
                alu_b    = ALU_BITS'(rate);
                alu_ctrl = '{sub: 1'b1};
                if (alu_res.neg)
                    rem_next = alu_a[RATE_BITS-1:0];
                else
                    rem_next = alu_res.sum[RATE_BITS-1:0];
                num_next = {num_reg[DIV_BITS-2:0], !alu_res.neg};
                cnt_next = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                alu_a = ALU_BITS'(num_reg);
                alu_b = ALU_ONE;
                if (alu_res.sum[ALU_BITS-1:WAIT_BITS] != '0)
                    wait_next = WAIT_MAX;
                else
                    wait_next = alu_res.sum[WAIT_BITS-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    oconf_next  = ok_reg;
                    owait_next  = wait_reg;
                    otok_next   = tok_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tok_reg    <= '0;
            last_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tok_reg    <= tok_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        len_reg   <= len_next;
        retry_reg <= retry_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        big_reg   <= big_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        ok_reg    <= ok_next;
        wait_reg  <= wait_next;
        oconf_reg <= oconf_next;
        owait_reg <= owait_next;
        otok_reg  <= otok_next;
    end

    assign res.valid       = ovalid_reg;
    assign res.conforms    = oconf_reg;
    assign res.wait_ticks  = owait_reg;
    assign res.tokens_left = otok_reg;

    a_take_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.ready |=> state_reg == S_DIFF)
        else $error("accepted item did not start the refill step");

    a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < rate)
        else $error("division remainder not below the rate");

    a_delay_marks_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !ok_reg |-> pend_reg)
        else $error("delayed packet left no pending mark");

    a_conform_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.conforms |-> res.wait_ticks == '0)
        else $error("conforming item carries a wait");

endmodule
